@@ design/lphs_pkg.sv @@
// Shared constants, types and control structs for the linear probing hash set.
package lphs_pkg;

  localparam int TABLE_SIZE = 16;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 8;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 4;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_DUP    = 2'd1,
    STATUS_FULL   = 2'd2,
    STATUS_ABSENT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_PROBE,
    CTRL_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic probe_en;
    logic out_load;
  } lphs_cmd_t;

  typedef struct packed {
    logic func_bad;
    logic probe_stop;
    logic out_busy;
  } lphs_stat_t;

endpackage

@@ design/lphs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/lphs_datapath.sv @@
// Datapath: probe pointer, slot status flops, key memory, result and output registers.
module lphs_datapath
  import lphs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lphs_cmd_t           cmd_i,
  output lphs_stat_t          stat_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_o
);

  idx_t                home;
  idx_t                idx_q;
  idx_t                idx_next;
  idx_t                count_q;
  idx_t                free_at_q;
  idx_t                free_now;
  idx_t                raddr;
  idx_t                st_waddr;
  logic                has_free_q;
  logic                has_free_now;
  logic [KEY_W-1:0]    key_q;
  logic [KEY_W-1:0]    rdata;
  func_e               func_q;
  slot_state_e         slot_state_q [TABLE_SIZE];
  slot_state_e         cur_st;
  slot_state_e         st_wdata;
  logic                is_empty;
  logic                is_used;
  logic                is_tomb;
  logic                match;
  logic                last;
  logic                stop;
  logic                ram_we;
  logic                st_we;
  status_e             res_status_q;
  status_e             res_status_d;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [SLOT_W-1:0]   res_slot_d;
  logic                out_valid_q;
  status_e             out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;

  assign home     = idx_t'(key_i % TABLE_SIZE);
  assign idx_next = (idx_q == idx_t'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
  assign raddr    = cmd_i.probe_en ? idx_next : home;

  lphs_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_SIZE)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_now),
    .wdata_i(key_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cur_st       = slot_state_q[idx_q];
  assign is_empty     = (cur_st == SLOT_EMPTY);
  assign is_used      = (cur_st == SLOT_USED);
  assign is_tomb      = !is_empty && !is_used;
  assign match        = is_used && (rdata == key_q);
  assign last         = (count_q == idx_t'(TABLE_SIZE - 1));
  assign stop         = is_empty || match || last;
  assign has_free_now = has_free_q || is_empty || is_tomb;
  assign free_now     = has_free_q ? free_at_q : idx_q;

  always_comb begin
    ram_we       = 1'b0;
    st_we        = 1'b0;
    st_waddr     = idx_q;
    st_wdata     = SLOT_TOMB;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    if (cmd_i.accept) begin
      res_status_d = STATUS_ABSENT;
      res_slot_d   = '0;
    end else if (cmd_i.probe_en && stop) begin
      res_status_d = STATUS_ABSENT;
      res_slot_d   = '0;
      case (func_q)
        FUNC_INSERT: begin
          if (match) begin
            res_status_d = STATUS_DUP;
            res_slot_d   = SLOT_W'(idx_q);
          end else if (has_free_now) begin
            ram_we       = 1'b1;
            st_we        = 1'b1;
            st_waddr     = free_now;
            st_wdata     = SLOT_USED;
            res_status_d = STATUS_OK;
            res_slot_d   = SLOT_W'(free_now);
          end else begin
            res_status_d = STATUS_FULL;
          end
        end
        FUNC_DELETE: begin
          if (match) begin
            st_we        = 1'b1;
            st_waddr     = idx_q;
            st_wdata     = SLOT_TOMB;
            res_status_d = STATUS_OK;
            res_slot_d   = SLOT_W'(idx_q);
          end
        end
        FUNC_LOOKUP: begin
          if (match) begin
            res_status_d = STATUS_OK;
            res_slot_d   = SLOT_W'(idx_q);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_free_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        slot_state_q[i] <= SLOT_EMPTY;
      end
    end else begin
      if (cmd_i.accept) begin
        has_free_q <= 1'b0;
      end else if (cmd_i.probe_en && !has_free_q && is_tomb) begin
        has_free_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (st_we) begin
        slot_state_q[st_waddr] <= st_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q   <= home;
      count_q <= '0;
      key_q   <= key_i;
      func_q  <= func_e'(func_i);
    end else if (cmd_i.probe_en) begin
      idx_q   <= idx_next;
      count_q <= count_q + 1'b1;
      if (!has_free_q && is_tomb) begin
        free_at_q <= idx_q;
      end
    end
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign stat_o.func_bad   = (func_i == FUNC_NONE);
  assign stat_o.probe_stop = stop;
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("Output register loaded while a result is still waiting.");

  a_insert_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.probe_en && stop && func_q == FUNC_INSERT && !match && has_free_now)
    |=> slot_state_q[$past(free_now)] == SLOT_USED)
    else $error("Inserted slot was not marked occupied.");

  a_delete_tomb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.probe_en && stop && func_q == FUNC_DELETE && match)
    |=> slot_state_q[$past(idx_q)] == SLOT_TOMB)
    else $error("Deleted slot was not marked as a tombstone.");

endmodule

@@ design/lphs_ctrl.sv @@
// Controller state machine that sequences accept, probe and result delivery.
module lphs_ctrl
  import lphs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lphs_stat_t stat_i,
  output lphs_cmd_t  cmd_o
);

  ctrl_state_e state_q;
  ctrl_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.func_bad ? CTRL_RESULT : CTRL_PROBE;
        end
      end
      CTRL_PROBE: begin
        cmd_o.probe_en = 1'b1;
        if (stat_i.probe_stop) begin
          state_d = CTRL_RESULT;
        end
      end
      CTRL_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = CTRL_IDLE;
        end
      end
      default: begin
        state_d = CTRL_IDLE;
      end
    endcase
  end

endmodule

@@ design/linear_probe_hash_set.sv @@
// Top level of the linear probing hash set: controller and datapath.
//
// The input channel (in_valid_i, in_ready_o) takes one item: an operation
// in func_i (insert, delete or lookup) and a key byte in key_i. The output
// channel (out_valid_o, out_ready_i) returns exactly one item per input
// item with status_o and slot_o, in input order.
// An accepted item probes one slot per cycle, starting at the home slot
// key modulo TABLE_SIZE, through a key RAM with registered read and the
// slot status flops. A probe visits 1 to TABLE_SIZE slots; an item is
// accepted, then probed, and its result is then loaded into the output
// register; the next item is taken only after that load. An unused
// operation code skips the probe and goes straight to the result.
// A new item is accepted while a finished result still waits in the
// output register. If the receiver stalls, the next result waits in the
// datapath until the output register frees, and no further item is taken.
// Reset marks all slots empty at once; no clearing pass is needed.
module linear_probe_hash_set
  import lphs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [KEY_W-1:0]    key_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   slot_o
);

  lphs_cmd_t  cmd;
  lphs_stat_t stat;

  lphs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lphs_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .func_i     (func_i),
    .key_i      (key_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .status_o   (status_o),
    .slot_o     (slot_o)
  );

endmodule

@@ bench/lphs_checker.sv @@
// Checker for the hash set: predicts each reply from the accepted items and compares.
module lphs_checker
  import lphs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [SLOT_W-1:0]   slot_i,
  output int                  fail_cnt_o,
  output int                  pending_o,
  output int                  checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    func_e              func;
    logic [KEY_W-1:0]   key;
    status_e            status;
    logic [SLOT_W-1:0]  slot;
  } reply_t;

  logic [KEY_W-1:0] table_key [TABLE_SIZE];
  slot_state_e      table_st  [TABLE_SIZE];
  reply_t           reply_q   [$];
  int               fail_cnt;
  int               checked;

  function automatic reply_t apply_table_op(func_e op, logic [KEY_W-1:0] k);
    reply_t rep;
    idx_t   idx;
    idx_t   hit_at;
    idx_t   free_at;
    bit     found;
    bit     has_free;
    bit     stop;
    rep.func   = op;
    rep.key    = k;
    rep.status = STATUS_ABSENT;
    rep.slot   = '0;
    idx      = idx_t'(int'(k) % TABLE_SIZE);
    hit_at   = '0;
    free_at  = '0;
    found    = 1'b0;
    has_free = 1'b0;
    stop     = 1'b0;
    if (op == FUNC_NONE) begin
      return rep;
    end
    for (int n = 0; n < TABLE_SIZE && !stop; n++) begin
      case (table_st[idx])
        SLOT_EMPTY: begin
          if (!has_free) begin
            has_free = 1'b1;
            free_at  = idx;
          end
          stop = 1'b1;
        end
        SLOT_USED: begin
          if (table_key[idx] == k) begin
            found  = 1'b1;
            hit_at = idx;
            stop   = 1'b1;
          end
        end
        default: begin
          if (!has_free) begin
            has_free = 1'b1;
            free_at  = idx;
          end
        end
      endcase
      idx = (int'(idx) == TABLE_SIZE - 1) ? '0 : idx + 1'b1;
    end
    if (op == FUNC_INSERT) begin
      if (found) begin
        rep.status = STATUS_DUP;
        rep.slot   = SLOT_W'(hit_at);
      end else if (has_free) begin
        table_key[free_at] = k;
        table_st[free_at]  = SLOT_USED;
        rep.status = STATUS_OK;
        rep.slot   = SLOT_W'(free_at);
      end else begin
        rep.status = STATUS_FULL;
      end
    end else if (found) begin
      if (op == FUNC_DELETE) begin
        table_st[hit_at] = SLOT_TOMB;
      end
      rep.status = STATUS_OK;
      rep.slot   = SLOT_W'(hit_at);
    end
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        table_st[i] = SLOT_EMPTY;
      end
      reply_q.delete();
      fail_cnt = 0;
      checked  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected reply, got status %0d slot %0d", $time, status_i, slot_i);
          fail_cnt++;
        end else begin
          want = reply_q.pop_front();
          checked++;
          if (status_i !== want.status) begin
            $display("%0t: status mismatch for func %0d key %02h: expected %0d, got %0d",
                     $time, want.func, want.key, want.status, status_i);
            fail_cnt++;
          end
          if (slot_i !== want.slot) begin
            $display("%0t: slot mismatch for func %0d key %02h: expected %0d, got %0d",
                     $time, want.func, want.key, want.slot, slot_i);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        reply_q.push_back(apply_table_op(func_e'(func_i), key_i));
      end
    end
    fail_cnt_o <= fail_cnt;
    pending_o  <= reply_q.size();
    checked_o  <= checked;
  end

endmodule

@@ bench/testbench.sv @@
// Top of the hash set testbench: clock, reset, stimulus, output flow control and verdict.
module testbench
  import lphs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS     = 1350;
  localparam int QUIET_ITEMS = 150;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 120;
  localparam int DRAIN       = TABLE_SIZE + 8;
  localparam int LIMIT       = 400000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FUNC_W-1:0]   func = '0;
  logic [KEY_W-1:0]    key = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  int fail_cnt;
  int pending;
  int checked;
  int sent_cnt = 0;
  int cycle_cnt = 0;
  int op_cnt [4] = '{0, 0, 0, 0};
  bit hold_done = 1'b0;
  bit quiet = 1'b0;

  always #6 clk = ~clk;

  linear_probe_hash_set dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (func),
    .key_i       (key),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .slot_o      (slot)
  );

  lphs_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .func_i      (func),
    .key_i       (key),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .status_i    (status),
    .slot_i      (slot),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  task automatic send_item(func_e op, logic [KEY_W-1:0] k);
    in_valid <= 1'b1;
    func     <= op;
    key      <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    op_cnt[op]++;
    quiet = (sent_cnt >= N_ITEMS - QUIET_ITEMS);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin : receiver
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key_pool [24];
    logic [KEY_W-1:0] k;
    func_e            op;
    int               pool_n;
    int               mode;
    int               base;
    int               ins_w;
    int               del_w;
    int               phase_len;
    int               r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FUNC_LOOKUP, 8'h05);
    send_item(FUNC_DELETE, 8'h05);
    send_item(FUNC_NONE,   8'hAA);
    send_item(FUNC_INSERT, 8'h00);
    send_item(FUNC_INSERT, 8'h10);
    send_item(FUNC_INSERT, 8'h00);
    send_item(FUNC_DELETE, 8'h00);
    send_item(FUNC_LOOKUP, 8'h10);
    send_item(FUNC_INSERT, 8'hFF);
    send_item(FUNC_INSERT, 8'h20);
    for (int j = 2; j < 15; j++) begin
      send_item(FUNC_INSERT, 8'(j));
    end
    send_item(FUNC_INSERT, 8'h80);
    send_item(FUNC_LOOKUP, 8'h81);

    while (sent_cnt < N_ITEMS) begin
      pool_n = $urandom_range(3, 24);
      mode   = $urandom_range(0, 2);
      base   = $urandom_range(0, 15);
      for (int j = 0; j < pool_n; j++) begin
        case (mode)
          0:       key_pool[j] = 8'($urandom);
          1:       key_pool[j] = 8'(base + 16 * $urandom_range(0, 15));
          default: key_pool[j] = 8'(base + $urandom_range(0, 3) + 16 * $urandom_range(0, 15));
        endcase
      end
      ins_w     = $urandom_range(20, 70);
      del_w     = $urandom_range(10, 30);
      phase_len = $urandom_range(30, 90);
      for (int n = 0; n < phase_len && sent_cnt < N_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          op = FUNC_NONE;
          k  = 8'($urandom);
        end else if (r < 8) begin
          op = func_e'($urandom_range(0, 2));
          k  = 8'($urandom);
        end else begin
          k = key_pool[$urandom_range(0, pool_n - 1)];
          r = $urandom_range(0, 99);
          if (r < ins_w) begin
            op = FUNC_INSERT;
          end else if (r < ins_w + del_w) begin
            op = FUNC_DELETE;
          end else begin
            op = FUNC_LOOKUP;
          end
        end
        send_item(op, k);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("tb: %0d items sent: %0d insert, %0d delete, %0d lookup, %0d unused code",
             sent_cnt, op_cnt[FUNC_INSERT], op_cnt[FUNC_DELETE], op_cnt[FUNC_LOOKUP],
             op_cnt[FUNC_NONE]);
    $display("tb: %0d replies checked, one output hold of %0d cycles, %0d cycles run",
             checked, HOLD_CYCLES, cycle_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ linear_probe_hash_set.f @@
design/lphs_pkg.sv
design/lphs_ram.sv
design/lphs_datapath.sv
design/lphs_ctrl.sv
design/linear_probe_hash_set.sv
bench/lphs_checker.sv
bench/testbench.sv
